// ===== rtl/core/kvenc_pkg.sv =====
package kvenc_pkg;

  localparam int unsigned LETTERS   = 26;
  localparam int unsigned KEY_DEPTH = 32;

  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned KEY_IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KEY_LEN_W = $clog2(KEY_DEPTH + 1);

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7a;

  // Item modes
  localparam logic [1:0] MODE_KEYWORD = 2'd0;
  localparam logic [1:0] MODE_KEY     = 2'd1;
  localparam logic [1:0] MODE_ENCODE  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_VALID     = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
    logic       first;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [1:0] status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic pos_rd;
    logic alph_rd;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic route_sweep;
    logic route_encode;
    logic sweep_done;
  } stat_t;

endpackage

// ===== rtl/core/kvenc_ctrl.sv =====
module kvenc_ctrl import kvenc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_POS    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, load;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  // Load the output register once it is empty or being drained.
  assign load   = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.route_sweep) begin
            state_d = S_SWEEP;
          end else if (stat_i.route_encode) begin
            state_d = S_POS;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SWEEP: begin
        if (stat_i.sweep_done) begin
          state_d = S_FINISH;
        end
      end
      S_POS:    state_d = S_SUM;
      S_SUM:    state_d = S_FINISH;
      S_FINISH: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cmd_o.accept     = accept;
  assign cmd_o.sweep      = (state_q == S_SWEEP);
  assign cmd_o.pos_rd     = (state_q == S_POS);
  assign cmd_o.alph_rd    = (state_q == S_SUM);
  assign cmd_o.load_out   = load;

endmodule

// ===== rtl/core/kvenc_dp.sv =====
module kvenc_dp import kvenc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  out_data_o
);

  // Keyed alphabet, letter positions and key letters
  logic [LETTER_W-1:0] alph_mem [LETTERS];
  logic [LETTER_W-1:0] pos_mem  [LETTERS];
  logic [LETTER_W-1:0] key_mem  [KEY_DEPTH];

  // Control state
  logic [LETTERS-1:0]   used_q, used_d;
  logic [LETTER_W-1:0]  fill_q, fill_d;
  logic                 ready_q, ready_d;
  logic [KEY_LEN_W-1:0] key_len_q, key_len_d;
  logic [KEY_IDX_W-1:0] key_pos_q, key_pos_d;
  logic [LETTER_W-1:0]  sweep_q;

  // Payload
  logic [LETTER_W-1:0]  plain_q;
  logic [LETTER_W-1:0]  key_rd_q;
  logic [LETTER_W-1:0]  p_rd_q, k_rd_q;
  logic [LETTER_W-1:0]  alph_rd_q;
  logic [1:0]           st_q, st_d;
  out_t                 out_q;

  logic                 is_lower;
  logic [7:0]           sym_off;
  logic [LETTER_W-1:0]  letter;
  logic [LETTERS-1:0]   letter_bit, sweep_bit;
  logic [LETTERS-1:0]   eff_used;
  logic [LETTER_W-1:0]  eff_fill;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_IDX_W-1:0] kp_eff, kp_use;
  logic [KEY_LEN_W-1:0] kp_inc;
  logic                 enc_ok;

  logic                 alph_we;
  logic [LETTER_W-1:0]  alph_waddr, alph_wdata;
  logic                 key_we;
  logic [LETTER_W-1:0]  sum_idx;
  logic [LETTER_W:0]    sum_raw;

  assign is_lower   = (in_data_i.symbol >= CHAR_A) && (in_data_i.symbol <= CHAR_Z);
  assign sym_off    = in_data_i.symbol - CHAR_A;
  assign letter     = sym_off[LETTER_W-1:0];
  assign letter_bit = LETTERS'(1) << letter;
  assign sweep_bit  = LETTERS'(1) << sweep_q;

  assign eff_used = in_data_i.first ? '0 : used_q;
  assign eff_fill = in_data_i.first ? '0 : fill_q;
  assign eff_len  = in_data_i.first ? '0 : key_len_q;

  // Key position for this beat: restart on first, wrap past the key end.
  assign kp_eff = in_data_i.first ? '0 : key_pos_q;
  assign kp_use = (KEY_LEN_W'(kp_eff) >= key_len_q) ? '0 : kp_eff;
  assign kp_inc = KEY_LEN_W'(kp_use) + KEY_LEN_W'(1);

  assign enc_ok = ready_q && (key_len_q != '0) && is_lower;

  assign stat_o.route_sweep  = (in_data_i.mode == MODE_KEYWORD) && in_data_i.last;
  assign stat_o.route_encode = (in_data_i.mode == MODE_ENCODE) && enc_ok;
  assign stat_o.sweep_done   = (sweep_q == LETTER_W'(LETTERS - 1));

  always_comb begin
    used_d     = used_q;
    fill_d     = fill_q;
    ready_d    = ready_q;
    key_len_d  = key_len_q;
    key_pos_d  = key_pos_q;
    st_d       = st_q;
    alph_we    = 1'b0;
    alph_waddr = fill_q;
    alph_wdata = sweep_q;
    key_we     = 1'b0;

    if (cmd_i.accept) begin
      st_d = ST_INVALID;
      case (in_data_i.mode)
        MODE_KEYWORD: begin
          used_d  = eff_used;
          fill_d  = eff_fill;
          ready_d = in_data_i.first ? 1'b0 : ready_q;
          if (is_lower) begin
            st_d = ST_LOADED;
            if ((eff_fill < LETTER_W'(LETTERS)) && ((eff_used & letter_bit) == '0)) begin
              alph_we    = 1'b1;
              alph_waddr = eff_fill;
              alph_wdata = letter;
              used_d     = eff_used | letter_bit;
              fill_d     = eff_fill + LETTER_W'(1);
            end
          end
        end
        MODE_KEY: begin
          key_len_d = eff_len;
          if (in_data_i.first) begin
            key_pos_d = '0;
          end
          if (is_lower && (eff_len < KEY_LEN_W'(KEY_DEPTH))) begin
            key_we    = 1'b1;
            key_len_d = eff_len + KEY_LEN_W'(1);
            st_d      = ST_LOADED;
          end
        end
        MODE_ENCODE: begin
          key_pos_d = kp_eff;
          if (!ready_q || (key_len_q == '0)) begin
            st_d = ST_NOT_READY;
          end else if (is_lower) begin
            st_d      = ST_VALID;
            key_pos_d = (kp_inc >= key_len_q) ? '0 : kp_inc[KEY_IDX_W-1:0];
          end
        end
        default: st_d = ST_INVALID;
      endcase
    end else if (cmd_i.sweep) begin
      // Append the remaining letters in order, one a cycle.
      if ((fill_q < LETTER_W'(LETTERS)) && ((used_q & sweep_bit) == '0)) begin
        alph_we    = 1'b1;
        alph_waddr = fill_q;
        alph_wdata = sweep_q;
        used_d     = used_q | sweep_bit;
        fill_d     = fill_q + LETTER_W'(1);
      end
      if (stat_o.sweep_done) begin
        ready_d = 1'b1;
      end
    end
  end

  assign sum_raw = {1'b0, p_rd_q} + {1'b0, k_rd_q};
  assign sum_idx = (sum_raw >= (LETTER_W+1)'(LETTERS)) ?
                   LETTER_W'(sum_raw - (LETTER_W+1)'(LETTERS)) : sum_raw[LETTER_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      fill_q    <= '0;
      ready_q   <= 1'b0;
      key_len_q <= '0;
      key_pos_q <= '0;
      sweep_q   <= '0;
    end else begin
      used_q    <= used_d;
      fill_q    <= fill_d;
      ready_q   <= ready_d;
      key_len_q <= key_len_d;
      key_pos_q <= key_pos_d;
      if (cmd_i.accept) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep) begin
        sweep_q <= sweep_q + LETTER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (alph_we) begin
      alph_mem[alph_waddr] <= alph_wdata;
      pos_mem[alph_wdata]  <= alph_waddr;
    end
    if (key_we) begin
      key_mem[eff_len[KEY_IDX_W-1:0]] <= letter;
    end
    if (cmd_i.accept) begin
      plain_q  <= letter;
      key_rd_q <= key_mem[kp_use];
    end
    if (cmd_i.pos_rd) begin
      p_rd_q <= pos_mem[plain_q];
      k_rd_q <= pos_mem[key_rd_q];
    end
    if (cmd_i.alph_rd) begin
      alph_rd_q <= alph_mem[sum_idx];
    end
    if (cmd_i.load_out) begin
      out_q.status     <= st_q;
      out_q.out_symbol <= (st_q == ST_VALID) ? (CHAR_A + 8'(alph_rd_q)) : 8'd0;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/keyed_vigenere_encoder.sv =====
// Keyed Vigenere encoder: one result beat for every input beat, one item at a time.
// Keyword, key and error beats go from IDLE straight to FINISH, an encoded byte through POS
// and SUM, a keyword beat with last set through SWEEP; the input stalls until FINISH loads
// the output register, so the pace is set by the memory read chain (key letter, letter
// positions, keyed alphabet) and by the 26-step alphabet sweep.
// Reset (rst_ni low, async) clears the alphabet, the key and any pending result.
module keyed_vigenere_encoder import kvenc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // The controller sequences each item; the datapath holds the alphabet,
  // position and key memories plus the output register. The output register
  // lets the next input beat be taken while a result still waits downstream.
  cmd_t  cmd;
  stat_t stat;

  kvenc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Encode path: read key letter on accept, then both letter positions,
  // then the keyed alphabet at their sum mod 26.
  kvenc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
